>>> sv/pdsrch_pkg.sv
package pdsrch_pkg;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned M_LOW = 7;
  localparam int unsigned M_HIGH = 14;
  localparam int unsigned CODE_LAST = 4;

  typedef enum logic [3:0] {
    REG_REF_FREQ   = 4'd0,
    REG_MIN_VCO    = 4'd1,
    REG_MAX_VCO    = 4'd2,
    REG_MAX_8BPP   = 4'd3,
    REG_MAX_16BPP  = 4'd4,
    REG_MAX_24BPP  = 4'd5,
    REG_MAX_32BPP  = 4'd6,
    REG_MAX_DUAL   = 4'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    CS_CMAP8 = 3'd0,
    CS_RGB15 = 3'd1,
    CS_RGB16 = 3'd2,
    CS_RGB24 = 3'd3,
    CS_RGB32 = 3'd4
  } color_space_t;

  typedef struct packed {
    logic [19:0] pixel_clock_khz;
    logic [2:0]  color_space;
    logic        dual_head;
  } in_beat_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  ref_divider;
    logic [7:0]  vco_multiplier;
    logic [2:0]  post_code;
    logic [23:0] achieved_khz;
  } out_beat_t;

  typedef struct packed {
    logic [16:0] ref_freq_khz;
    logic [19:0] min_vco_khz;
    logic [19:0] max_vco_khz;
    logic [19:0] max_clock_8bpp;
    logic [19:0] max_clock_16bpp;
    logic [19:0] max_clock_24bpp;
    logic [19:0] max_clock_32bpp;
    logic [19:0] max_clock_32bpp_dual;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CHECK,
    B_NCHK,
    B_NSTEP,
    B_MUL,
    B_TDIV,
    B_CMP,
    B_AMUL,
    B_ADIV,
    B_DONE
  } back_state_t;

endpackage

>>> sv/pdsrch_fifo.sv
module pdsrch_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [23:0] push_data,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output logic [23:0] pop_data
);
  logic [23:0] mem [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> sv/pdsrch_front.sv
module pdsrch_front (
  input  logic                  valid,
  output logic                  ready,
  input  pdsrch_pkg::in_beat_t  data,
  input  pdsrch_pkg::cfg_regs_t cfg,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [23:0]           q_data
);
  import pdsrch_pkg::*;

  logic [19:0] limit;
  logic [23:0] req16;
  logic [23:0] lim16;
  logic [23:0] lo_clamped;

  always_comb begin
    if (data.color_space == CS_RGB32 && data.dual_head) begin
      limit = cfg.max_clock_32bpp_dual;
    end else begin
      case (data.color_space)
        CS_CMAP8:          limit = cfg.max_clock_8bpp;
        CS_RGB15, CS_RGB16: limit = cfg.max_clock_16bpp;
        CS_RGB24:          limit = cfg.max_clock_24bpp;
        default:           limit = cfg.max_clock_32bpp;
      endcase
    end
  end

  assign req16      = {data.pixel_clock_khz, 4'b0};
  assign lim16      = {limit, 4'b0};
  assign lo_clamped = (req16 < 24'(cfg.min_vco_khz)) ? 24'(cfg.min_vco_khz) : req16;
  assign q_data     = (lo_clamped > lim16) ? lim16 : lo_clamped;
  assign ready      = ~q_full;
  assign q_push     = valid & ~q_full;
endmodule

>>> sv/pdsrch_back.sv
module pdsrch_back #(
  parameter int EXT_PLL_TWEAK     = 0,
  parameter int WIDE_PHASE_WINDOW = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pdsrch_pkg::cfg_regs_t cfg,
  input  logic                  q_empty,
  input  logic [23:0]           q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pdsrch_pkg::out_beat_t out_data
);
  import pdsrch_pkg::*;

  localparam int PH_LO = (WIDE_PHASE_WINDOW != 0) ? 3200 : 1000;
  localparam int PH_HI = (WIDE_PHASE_WINDOW != 0) ? 6400 : 2000;
  localparam int DSH   = (EXT_PLL_TWEAK != 0) ? 6 : 4;
  localparam int TSH   = (EXT_PLL_TWEAK != 0) ? 10 : 12;
  localparam int ASH   = (EXT_PLL_TWEAK != 0) ? 3 : 1;

  back_state_t state, state_next;

  logic [23:0] req16;
  logic [3:0]  m;
  logic [2:0]  code;
  logic [33:0] nrem;
  logic [7:0]  nq;
  logic [2:0]  ncnt;
  logic [24:0] prod;
  logic [47:0] sd_x;
  logic [47:0] sd_q;
  logic [3:0]  sd_r;
  logic [2:0]  sd_cnt;
  logic        found;
  logic [47:0] best_err;
  logic [3:0]  bm;
  logic [7:0]  bn;
  logic [2:0]  bcode;

  logic [27:0] vco16;
  logic [16:0] ph_lo_m;
  logic [16:0] ph_hi_m;
  logic        chk_ok;
  logic [23:0] dd;
  logic [33:0] numer;
  logic        n_ovf;
  logic [33:0] dsh;
  logic        n_ge;
  logic [7:0]  nq_fin;
  logic        last;
  logic [47:0] target;
  logic [47:0] term;
  logic [47:0] err;
  logic [3:0]  sr;
  logic [4:0]  st;
  logic [7:0]  sqb;
  logic        sd_done;
  logic        out_free;
  logic        do_pop;
  logic        do_out;

  assign vco16   = 28'(req16) << code;
  assign ph_lo_m = 17'(PH_LO) * 17'(m);
  assign ph_hi_m = 17'(PH_HI) * 17'(m);
  assign chk_ok  = (vco16 >= 28'({cfg.min_vco_khz, 4'b0}))
                && (vco16 <= 28'({cfg.max_vco_khz, 4'b0}))
                && (cfg.ref_freq_khz >= ph_lo_m) && (cfg.ref_freq_khz <= ph_hi_m);
  assign dd      = 24'({cfg.ref_freq_khz, 1'b0}) << DSH;
  assign numer   = ((34'(vco16) * 34'(m)) << 1) + 34'(dd >> 1);
  assign n_ovf   = numer >= (34'(dd) << 8);
  assign dsh     = 34'(dd) << ncnt;
  assign n_ge    = nrem >= dsh;
  assign nq_fin  = {nq[6:0], n_ge};
  assign last    = (code == 3'(CODE_LAST)) && (m == 4'(M_HIGH));
  assign target  = 48'(req16) << TSH;
  assign term    = sd_q >> code;
  assign err     = (target > term) ? (target - term) : (term - target);
  assign sd_done = (sd_cnt == 3'd5);
  assign out_free = ~out_valid | out_ready;

  always_comb begin
    sr  = sd_r;
    sqb = 8'd0;
    st  = 5'd0;
    for (int i = 7; i >= 0; i--) begin
      st = {sr, sd_x[40 + i]};
      if (st >= {1'b0, m}) begin
        sr     = 4'(st - {1'b0, m});
        sqb[i] = 1'b1;
      end else begin
        sr = st[3:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!q_empty) state_next = B_CHECK;
      B_CHECK: begin
        if (chk_ok) state_next = B_NCHK;
        else if (last) state_next = found ? B_AMUL : B_DONE;
      end
      B_NCHK: begin
        if (!n_ovf) state_next = B_NSTEP;
        else if (last) state_next = found ? B_AMUL : B_DONE;
        else state_next = B_CHECK;
      end
      B_NSTEP: begin
        if (ncnt == 3'd0) begin
          if (nq_fin != 8'd0) state_next = B_MUL;
          else if (last) state_next = found ? B_AMUL : B_DONE;
          else state_next = B_CHECK;
        end
      end
      B_MUL:   state_next = B_TDIV;
      B_TDIV:  if (sd_done) state_next = B_CMP;
      B_CMP:   state_next = last ? B_AMUL : B_CHECK;
      B_AMUL:  state_next = B_ADIV;
      B_ADIV:  if (sd_done) state_next = B_DONE;
      B_DONE:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    do_pop = 1'b0;
    do_out = 1'b0;
    case (state)
      B_IDLE:  do_pop = ~q_empty;
      B_DONE:  do_out = out_free;
      default: ;
    endcase
  end

  assign q_pop = do_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // candidate walk, p ascending then m ascending
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        req16 <= q_data;
        m     <= 4'(M_LOW);
        code  <= 3'd0;
        found <= 1'b0;
      end
      B_NCHK: begin
        nrem <= numer;
        nq   <= 8'd0;
        ncnt <= 3'd7;
      end
      B_NSTEP: begin
        if (n_ge) nrem <= nrem - dsh;
        nq   <= nq_fin;
        ncnt <= ncnt - 3'd1;
      end
      B_MUL: begin
        sd_x   <= 48'(25'(cfg.ref_freq_khz) * 25'(nq)) << 16;
        sd_r   <= 4'd0;
        sd_cnt <= 3'd0;
      end
      B_AMUL: begin
        m    <= bm;
        code <= bcode;
        prod <= 25'(cfg.ref_freq_khz) * 25'(bn);
      end
      B_TDIV, B_ADIV: begin
        if (state == B_ADIV && sd_cnt == 3'd0) begin
          sd_x <= ((48'(prod) << ASH) + (48'(m) << code)) << 8;
        end else begin
          sd_x <= sd_x << 8;
        end
        sd_q   <= {sd_q[39:0], sqb};
        sd_r   <= sr;
        sd_cnt <= sd_cnt + 3'd1;
      end
      B_CMP: begin
        if (!found || err < best_err) begin
          found    <= 1'b1;
          best_err <= err;
          bm       <= m;
          bn       <= nq;
          bcode    <= code;
        end
      end
      default: ;
    endcase
    if (state == B_AMUL) begin
      sd_r   <= 4'd0;
      sd_cnt <= 3'd0;
    end
    if (state == B_CHECK && !chk_ok || state == B_NCHK && n_ovf
        || state == B_NSTEP && ncnt == 3'd0 && nq_fin == 8'd0 || state == B_CMP) begin
      if (m == 4'(M_HIGH)) begin
        m    <= 4'(M_LOW);
        code <= code + 3'd1;
      end else begin
        m <= m + 4'd1;
      end
    end
    if (do_out) begin
      out_data.found          <= found;
      out_data.ref_divider    <= found ? bm : 4'd0;
      out_data.vco_multiplier <= found ? bn : 8'd0;
      out_data.post_code      <= found ? bcode : 3'd0;
      out_data.achieved_khz   <= found ? 24'(sd_q >> (code + 3'd1)) : 24'd0;
    end
  end
endmodule

>>> sv/pixel_pll_divider_search_top.sv
// per-beat processing time is set by the candidate walk in the back end over 40 candidates
// (a candidate out of range skips the n and error division that the others go through)
// the back end works on one beat at a time; a two-entry queue takes new beats meanwhile
// reset: synchronous, active high; config registers return to their defaults, queue empties
module pixel_pll_divider_search_top #(
  parameter int EXT_PLL_TWEAK     = 0,
  parameter int WIDE_PHASE_WINDOW = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pdsrch_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pdsrch_pkg::out_beat_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_index,
  input  logic [19:0]           cfg_data
);
  import pdsrch_pkg::*;

  cfg_regs_t   cfg;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  logic [23:0] q_in;
  logic [23:0] q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_freq_khz         <= 17'd27000;
      cfg.min_vco_khz          <= 20'd128000;
      cfg.max_vco_khz          <= 20'd350000;
      cfg.max_clock_8bpp       <= 20'd350000;
      cfg.max_clock_16bpp      <= 20'd350000;
      cfg.max_clock_24bpp      <= 20'd350000;
      cfg.max_clock_32bpp      <= 20'd350000;
      cfg.max_clock_32bpp_dual <= 20'd300000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REF_FREQ:  cfg.ref_freq_khz         <= cfg_data[16:0];
        REG_MIN_VCO:   cfg.min_vco_khz          <= cfg_data;
        REG_MAX_VCO:   cfg.max_vco_khz          <= cfg_data;
        REG_MAX_8BPP:  cfg.max_clock_8bpp       <= cfg_data;
        REG_MAX_16BPP: cfg.max_clock_16bpp      <= cfg_data;
        REG_MAX_24BPP: cfg.max_clock_24bpp      <= cfg_data;
        REG_MAX_32BPP: cfg.max_clock_32bpp      <= cfg_data;
        REG_MAX_DUAL:  cfg.max_clock_32bpp_dual <= cfg_data;
        default: ;
      endcase
    end
  end

  pdsrch_front u_front (
    .valid  (in_valid),
    .ready  (in_ready),
    .data   (in_data),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  pdsrch_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  pdsrch_back #(
    .EXT_PLL_TWEAK     (EXT_PLL_TWEAK),
    .WIDE_PHASE_WINDOW (WIDE_PHASE_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
